/* sv/m3d_pkg.sv */
package m3d_pkg;

  // geometry
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned LINE_AW   = $clog2(MAX_WIDTH);
  localparam int unsigned CFG_AW    = 2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_INV_DEPTH_STEP = 2'd2;
  localparam logic [CFG_AW-1:0] REG_INV_DEPTH_MIN  = 2'd3;

  // reset values of the registers
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  // input operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

  // 1000 in Q.28
  localparam logic [37:0] DEPTH_NUM = 38'd268435456000;

  // median exchange network, split into two register stages
  localparam int unsigned NET_LEN   = 19;
  localparam int unsigned NET_SPLIT = 10;
  localparam int NET_A [NET_LEN] = '{1,4,7,0,3,6,1,4,7,0,5,4,3,1,2,4,4,6,4};
  localparam int NET_B [NET_LEN] = '{2,5,8,1,4,7,2,5,8,3,8,7,6,4,5,7,2,4,2};

  typedef logic [8:0][15:0] win_t;

  // one disparity on its way to the depth stage
  typedef struct packed {
    logic [15:0] disp;
    logic        last;
  } item_t;

  // compare-exchange on signed values
  function automatic win_t cmpx(win_t v, int i, int j);
    logic [15:0] a;
    logic [15:0] b;
    a = v[i];
    b = v[j];
    if ($signed(b) < $signed(a)) begin
      v[i] = b;
      v[j] = a;
    end
    return v;
  endfunction

  // first part of the network
  function automatic win_t med_stage_a(win_t v);
    win_t r;
    r = v;
    for (int k = 0; k < NET_SPLIT; k++) begin
      r = cmpx(r, NET_A[k], NET_B[k]);
    end
    return r;
  endfunction

  // remaining exchanges
  function automatic win_t med_stage_b(win_t v);
    win_t r;
    r = v;
    for (int k = NET_SPLIT; k < NET_LEN; k++) begin
      r = cmpx(r, NET_A[k], NET_B[k]);
    end
    return r;
  endfunction

endpackage

/* sv/m3d_ram.sv */
module m3d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/m3d_front.sv */
module m3d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [10:0]       image_width_i,
  input  logic [11:0]       image_height_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic              operation_i,
  input  logic [15:0]       disparity_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output m3d_pkg::item_t    q_item_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FLUSH = 3'd1;
  localparam logic [2:0] S_PIX   = 3'd2;
  localparam logic [2:0] S_MED1  = 3'd3;
  localparam logic [2:0] S_MED2  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [9:0]  col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [10:0] pend_q, pend_d;
  m3d_pkg::win_t win_q, win_d;
  m3d_pkg::win_t med_q, med_d;
  logic [15:0] px_q, px_d;
  logic        sel_up_q, sel_up_d;
  logic        last_q, last_d;

  logic [10:0] w_eff;
  logic [11:0] h_eff;
  logic [11:0] wp1;
  logic [11:0] pend_ext;
  logic [11:0] pend_eff;
  logic [11:0] pend_inc;
  logic        accept;
  logic        flush_take;
  logic [10:0] flush_addr;
  logic        re;
  logic [m3d_pkg::LINE_AW-1:0] raddr;
  logic        we;
  logic [15:0] up_rd, mid_rd;
  logic [11:0] orow;
  logic        interior;
  logic        emit;
  m3d_pkg::win_t med_b;

  // effective frame geometry
  always_comb begin
    if (image_width_i < 11'd8) begin
      w_eff = 11'd8;
    end else if (image_width_i > 11'(m3d_pkg::MAX_WIDTH)) begin
      w_eff = 11'(m3d_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width_i;
    end
    h_eff = (image_height_i < 12'd3) ? 12'd3 : image_height_i;
  end

  assign wp1      = {1'b0, w_eff} + 12'd1;
  assign pend_ext = {1'b0, pend_q};
  assign pend_eff = (pend_ext > wp1) ? wp1 : pend_ext;
  assign pend_inc = pend_ext + 12'd1;

  assign ready_o    = (state_q == S_IDLE) && !q_full_i;
  assign accept     = valid_i && ready_o;
  assign flush_take = (col_q == '0) && (row_q == '0) && (pend_q != '0);
  assign flush_addr = (pend_eff == wp1) ? (w_eff - 11'd1) : (w_eff - pend_eff[10:0]);

  // line store read address
  always_comb begin
    re    = accept;
    raddr = col_q;
    if (operation_i == m3d_pkg::OP_FLUSH) begin
      raddr = flush_addr[m3d_pkg::LINE_AW-1:0];
    end
  end

  assign we = (state_q == S_PIX);

  m3d_ram #(.WIDTH(16), .DEPTH(m3d_pkg::MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (col_q),
    .wdata_i (mid_rd),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (up_rd)
  );

  m3d_ram #(.WIDTH(16), .DEPTH(m3d_pkg::MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (col_q),
    .wdata_i (px_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (mid_rd)
  );

  // output row and interior test for the pixel being shifted in
  assign orow     = (row_q >= 12'd1) ? (row_q - 12'd1) : (h_eff - 12'd1);
  assign interior = (col_q >= 10'd2) && ({1'b0, col_q} <= (w_eff - 11'd1))
                    && (orow >= 12'd1) && (orow <= (h_eff - 12'd2));
  assign emit     = pend_inc > wp1;
  assign med_b    = m3d_pkg::med_stage_b(med_q);

  // sequencer
  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    pend_d   = pend_q;
    win_d    = win_q;
    med_d    = med_q;
    px_d     = px_q;
    sel_up_d = sel_up_q;
    last_d   = last_q;
    q_push_o = 1'b0;
    q_item_o = '{disp: win_q[4], last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          px_d = disparity_i;
          if (operation_i == m3d_pkg::OP_PIXEL) begin
            state_d = S_PIX;
          end else if (flush_take) begin
            sel_up_d = (pend_eff == wp1);
            last_d   = (pend_eff == 12'd1);
            pend_d   = 11'(pend_eff - 12'd1);
            state_d  = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        q_push_o = 1'b1;
        q_item_o = '{disp: (sel_up_q ? up_rd : mid_rd), last: last_q};
        state_d  = S_IDLE;
      end
      S_PIX: begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = up_rd;
        win_d[3] = win_q[4];
        win_d[4] = win_q[5];
        win_d[5] = mid_rd;
        win_d[6] = win_q[7];
        win_d[7] = win_q[8];
        win_d[8] = px_q;
        state_d  = S_IDLE;
        if (emit) begin
          pend_d = wp1[10:0];
          if (col_q == '0) begin
            q_push_o = 1'b1;
            q_item_o = '{disp: win_q[5], last: (row_q == 12'd1)};
          end else if (interior) begin
            state_d = S_MED1;
          end else begin
            q_push_o = 1'b1;
            q_item_o = '{disp: win_q[5], last: 1'b0};
          end
        end else begin
          pend_d = pend_inc[10:0];
        end
        // raster position
        if (({1'b0, col_q} + 11'd1) >= w_eff) begin
          col_d = '0;
          row_d = (({1'b0, row_q} + 13'd1) >= {1'b0, h_eff}) ? '0 : (row_q + 12'd1);
        end else begin
          col_d = col_q + 10'd1;
        end
      end
      S_MED1: begin
        med_d   = m3d_pkg::med_stage_a(win_q);
        state_d = S_MED2;
      end
      S_MED2: begin
        q_push_o = 1'b1;
        q_item_o = '{disp: med_b[4], last: 1'b0};
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      win_q   <= win_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    med_q    <= med_d;
    px_q     <= px_d;
    sel_up_q <= sel_up_d;
    last_q   <= last_d;
  end

endmodule

/* sv/m3d_queue.sv */
module m3d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  m3d_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output m3d_pkg::item_t item_o,
  output logic           empty_o
);

  m3d_pkg::item_t           mem_q [m3d_pkg::QDEPTH];
  logic [m3d_pkg::QAW-1:0]  wptr_q, rptr_q;
  logic [m3d_pkg::QAW:0]    cnt_q;

  assign full_o  = (cnt_q == (m3d_pkg::QAW+1)'(m3d_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (m3d_pkg::QAW+1)'(push_i) - (m3d_pkg::QAW+1)'(pop_i);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (m3d_pkg::QAW+1)'(m3d_pkg::QDEPTH)) else $error("queue count out of range");
`endif

endmodule

/* sv/m3d_back.sv */
module m3d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    inv_depth_step_i,
  input  logic [31:0]    inv_depth_min_i,
  input  logic           q_empty_i,
  input  m3d_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_pop_i,
  output logic [15:0]    depth_mm_o,
  output logic           last_of_frame_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_DEN  = 3'd2;
  localparam logic [2:0] B_SAT  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        ovalid_q, ovalid_d;
  logic [15:0] depth_q, depth_d;
  logic        olast_q, olast_d;
  logic [14:0] d_q, d_d;
  logic        last_q, last_d;
  logic [46:0] prod_q, prod_d;
  logic [47:0] den_q, den_d;
  logic [37:0] rem_q, rem_d;
  logic [62:0] dsh_q, dsh_d;
  logic [15:0] quo_q, quo_d;
  logic [3:0]  bit_q, bit_d;
  logic        fits;

  assign fits = {25'd0, rem_q} >= dsh_q;

  // depth sequencer: multiply, add, saturation test, restoring divide
  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    depth_d  = depth_q;
    olast_d  = olast_q;
    d_d      = d_q;
    last_d   = last_q;
    prod_d   = prod_q;
    den_d    = den_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quo_d    = quo_q;
    bit_d    = bit_q;
    q_pop_o  = 1'b0;
    if (out_pop_i && ovalid_q) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i && !ovalid_q) begin
          q_pop_o = 1'b1;
          if (q_item_i.disp[15]) begin
            ovalid_d = 1'b1;
            depth_d  = '0;
            olast_d  = q_item_i.last;
          end else begin
            d_d     = q_item_i.disp[14:0];
            last_d  = q_item_i.last;
            state_d = B_MUL;
          end
        end
      end
      B_MUL: begin
        prod_d  = {15'd0, inv_depth_step_i} * {32'd0, d_q};
        state_d = B_DEN;
      end
      B_DEN: begin
        den_d   = {1'b0, prod_q} + {12'd0, inv_depth_min_i, 4'd0};
        state_d = B_SAT;
      end
      B_SAT: begin
        if ({26'd0, m3d_pkg::DEPTH_NUM} >= {den_q, 16'd0}) begin
          ovalid_d = 1'b1;
          depth_d  = 16'hFFFF;
          olast_d  = last_q;
          state_d  = B_IDLE;
        end else begin
          rem_d   = m3d_pkg::DEPTH_NUM;
          dsh_d   = {den_q, 15'd0};
          quo_d   = '0;
          bit_d   = 4'd15;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (fits) begin
          rem_d = rem_q - dsh_q[37:0];
        end
        quo_d = {quo_q[14:0], fits};
        dsh_d = dsh_q >> 1;
        bit_d = bit_q - 4'd1;
        if (bit_q == '0) begin
          ovalid_d = 1'b1;
          depth_d  = {quo_q[14:0], fits};
          olast_d  = last_q;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    depth_q <= depth_d;
    olast_q <= olast_d;
    d_q     <= d_d;
    last_q  <= last_d;
    prod_q  <= prod_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    bit_q   <= bit_d;
  end

  assign out_valid_o     = ovalid_q;
  assign depth_mm_o      = depth_q;
  assign last_of_frame_o = olast_q;

`ifndef SYNTHESIS
  a_pop_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (!ovalid_q && state_q == B_IDLE)) else $error("pop while busy");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_pop_i) |=> (ovalid_q && $stable(depth_q))) else $error("result lost");
  a_busy_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE) |-> !ovalid_q) else $error("output valid during divide");
`endif

endmodule

/* sv/median3x3_disparity_to_depth.sv */
// pixel: line store read, then window shift; the 3x3 median adds two network stages
// depth: an invalid disparity gives 0 from idle; a saturated one, FFFF after
// multiply, add and saturation test; else the bit-serial divide follows (16 divide steps)
// input: a new item is taken only while the front part is idle and the queue not full;
// the back part works on one item at a time; a two-entry queue decouples the two parts
// reset (rst_ni low, asynchronous) clears counters, window and the queue; registers take
// width 640, height 480, step 0, min 0; line stores are not cleared
module median3x3_disparity_to_depth (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [15:0] disparity_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] depth_mm_o,
  output logic        last_of_frame_o
);

  logic [10:0] width_q;
  logic [11:0] height_q;
  logic [31:0] step_q;
  logic [31:0] min_q;

  logic           front_ready;
  logic           q_push, q_full, q_pop, q_empty;
  m3d_pkg::item_t q_in, q_out;
  logic           out_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= m3d_pkg::WIDTH_RESET;
      height_q <= m3d_pkg::HEIGHT_RESET;
      step_q   <= '0;
      min_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        m3d_pkg::REG_IMAGE_WIDTH:    width_q  <= cfg_data_i[10:0];
        m3d_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_data_i[11:0];
        m3d_pkg::REG_INV_DEPTH_STEP: step_q   <= cfg_data_i;
        m3d_pkg::REG_INV_DEPTH_MIN:  min_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full  = !front_ready;
  assign empty = !out_valid;

  m3d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .valid_i        (push),
    .ready_o        (front_ready),
    .operation_i    (operation_i),
    .disparity_i    (disparity_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_in)
  );

  m3d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  m3d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .inv_depth_step_i (step_q),
    .inv_depth_min_i  (min_q),
    .q_empty_i        (q_empty),
    .q_item_i         (q_out),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid),
    .out_pop_i        (pop),
    .depth_mm_o       (depth_mm_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule
